[rtl/gqr_pkg.sv]
// ----------------------------------------------------------------------------
// gqr_pkg
// Shared types, constants and arithmetic helpers for the Givens QR solver.
// ----------------------------------------------------------------------------
`default_nettype none

package gqr_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam int OUT_IDX_W = 4;

    typedef enum logic {
        K_MAT,
        K_RHS
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  last;
    } t_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? 64'(-v) : 64'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/gqr_fifo.sv]
// ----------------------------------------------------------------------------
// gqr_fifo
// Four-entry queue between the loader front and the solver back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gqr_fifo
    import gqr_pkg::*;
#(
    parameter int W = 40
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

[rtl/gqr_front.sv]
// ----------------------------------------------------------------------------
// gqr_front
// Input side: tracks the load position and tags each transfer as matrix
// entry or right-hand-side entry, marking the final one of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module gqr_front
    import gqr_pkg::*;
#(
    parameter int MAX_N = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [$clog2(MAX_N+1)-1:0]   i_n,
    input  wire logic                         i_clear,
    input  wire logic                         i_tvalid,
    output logic                              o_tready,
    input  wire logic [DATA_W-1:0]            i_tdata,
    input  wire logic                         i_full,
    output logic                              o_push,
    output t_ctl                              o_ctl,
    output logic [$clog2(MAX_N)-1:0]          o_row,
    output logic [$clog2(MAX_N)-1:0]          o_col,
    output logic [DATA_W-1:0]                 o_data
);

    localparam int IW = $clog2(MAX_N);
    localparam int NW = $clog2(MAX_N+1);

    logic [NW-1:0] r_row;
    logic [NW-1:0] r_col;
    logic          r_rhs;
    logic          row_end;
    logic          col_end;

    assign o_tready   = !i_full;
    assign o_push     = i_tvalid && !i_full;
    assign row_end    = (r_row + 1'b1 == i_n);
    assign col_end    = (r_col + 1'b1 == i_n);
    assign o_ctl.kind = r_rhs ? K_RHS : K_MAT;
    assign o_ctl.last = r_rhs && row_end;
    assign o_row      = r_row[IW-1:0];
    assign o_col      = r_col[IW-1:0];
    assign o_data     = i_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row <= '0;
            r_col <= '0;
            r_rhs <= 1'b0;
        end else if (o_push) begin
            if (r_rhs) begin
                r_row <= row_end ? '0 : r_row + 1'b1;
                r_rhs <= !row_end;
            end else if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + 1'b1;
                r_rhs <= row_end;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/gqr_back.sv]
// ----------------------------------------------------------------------------
// gqr_back
// Solver back end: stores the system, runs the Givens rotations with a
// shared multiplier, bit-serial square root and divider, back-substitutes
// and streams the solution out through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gqr_back
    import gqr_pkg::*;
#(
    parameter int MAX_N     = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [$clog2(MAX_N+1)-1:0]   i_n,
    input  wire logic                         i_pop_valid,
    output logic                              o_pop,
    input  wire t_ctl                         i_ctl,
    input  wire logic [$clog2(MAX_N)-1:0]     i_row,
    input  wire logic [$clog2(MAX_N)-1:0]     i_col,
    input  wire logic [DATA_W-1:0]            i_data,
    output logic                              o_tvalid,
    input  wire logic                         i_tready,
    output logic signed [DATA_W-1:0]          o_value,
    output logic [OUT_IDX_W-1:0]              o_index,
    output logic                              o_singular,
    output logic                              o_last
);

    localparam int IW = $clog2(MAX_N);
    localparam int NW = $clog2(MAX_N+1);
    localparam int AW = 2*IW;
    localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    typedef enum logic [4:0] {
        S_IDLE, S_PX, S_PY, S_PYW, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_DIV,
        S_RU, S_RV, S_RV2, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_BS0, S_BS1, S_BJ, S_BJ2, S_BJ3, S_BP, S_BP2, S_EA, S_EB
    } t_state;

    typedef enum logic [1:0] {
        D_C,
        D_S,
        D_X
    } t_dsel;

    function automatic logic signed [63:0] trunc_f(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v[63] ? ((v + RND) >>> FRAC_BITS) : (v >>> FRAC_BITS);
        return r;
    endfunction

    logic signed [31:0] r_mat [2**AW];
    logic signed [31:0] r_rhs [2**IW];
    logic signed [31:0] r_x   [2**IW];

    t_state             r_state;
    t_dsel              r_dsel;
    logic [NW-1:0]      r_i;
    logic [NW-1:0]      r_j;
    logic [NW-1:0]      r_k;
    logic signed [31:0] r_mrd;
    logic signed [31:0] r_rrd;
    logic signed [31:0] r_xrd;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_c;
    logic signed [31:0] r_s;
    logic signed [31:0] r_u;
    logic signed [31:0] r_v;
    logic signed [31:0] r_acc32;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic [63:0]        r_sq;
    logic [63:0]        r_root;
    logic [63:0]        r_bit;
    logic [64:0]        r_rem;
    logic [63:0]        r_dq;
    logic [63:0]        r_dvs;
    logic               r_dneg;
    logic [6:0]         r_dcnt;
    logic               r_sing;
    logic               r_ov;
    logic signed [31:0] r_ovalue;
    logic [OUT_IDX_W-1:0] r_oindex;
    logic               r_osing;
    logic               r_olast;

    logic [AW-1:0]      mat_ra;
    logic [IW-1:0]      rhs_ra;
    logic [IW-1:0]      x_ra;
    logic               mat_we;
    logic [AW-1:0]      mat_wa;
    logic signed [31:0] mat_wd;
    logic               rhs_we;
    logic [IW-1:0]      rhs_wa;
    logic signed [31:0] rhs_wd;
    logic               x_we;
    logic [IW-1:0]      x_wa;
    logic signed [31:0] x_wd;
    logic signed [31:0] m_a;
    logic signed [31:0] m_b;
    logic signed [63:0] m_p;
    logic               k_rhs;
    logic signed [31:0] rd_sel;
    logic signed [31:0] rot_j;
    logic signed [31:0] rot_i;
    logic signed [63:0] dq_s;
    logic [63:0]        sq_try;
    logic [64:0]        dv_try;
    logic               more_j;
    logic               more_i;
    logic               out_free;
    logic               emit;

    assign k_rhs    = (r_k == i_n);
    assign rd_sel   = k_rhs ? r_rrd : r_mrd;
    assign rot_j    = sat32(trunc_f(r_acc + r_prod));
    assign rot_i    = sat32(trunc_f(r_acc - r_prod));
    assign dq_s     = r_dneg ? -$signed(r_dq) : $signed(r_dq);
    assign sq_try   = r_root + r_bit;
    assign dv_try   = {r_rem[63:0], r_dq[63]};
    assign more_j   = ({1'b0, r_j} + 1'b1 < {1'b0, i_n});
    assign more_i   = ({1'b0, r_i} + 2'd2 < {1'b0, i_n});
    assign out_free = !r_ov || i_tready;
    assign emit     = (r_state == S_EB) && out_free;
    assign o_pop    = (r_state == S_IDLE) && i_pop_valid;
    assign m_p      = 64'(m_a) * 64'(m_b);

    always_comb begin
        mat_ra = {r_i[IW-1:0], r_i[IW-1:0]};
        rhs_ra = r_i[IW-1:0];
        x_ra   = r_k[IW-1:0];
        case (r_state)
            S_PY:    mat_ra = {r_j[IW-1:0], r_i[IW-1:0]};
            S_RU:    mat_ra = {r_i[IW-1:0], r_k[IW-1:0]};
            S_RV: begin
                mat_ra = {r_j[IW-1:0], r_k[IW-1:0]};
                rhs_ra = r_j[IW-1:0];
            end
            S_BJ: begin
                mat_ra = {r_i[IW-1:0], r_j[IW-1:0]};
                x_ra   = r_j[IW-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        m_a = r_px;
        m_b = r_px;
        case (r_state)
            S_SQ2: begin m_a = r_py;  m_b = r_py;  end
            S_M1:  begin m_a = r_s;   m_b = r_u;   end
            S_M2:  begin m_a = r_c;   m_b = r_v;   end
            S_M3:  begin m_a = r_c;   m_b = r_u;   end
            S_M4:  begin m_a = r_s;   m_b = r_v;   end
            S_BJ2: begin m_a = r_mrd; m_b = r_xrd; end
            default: ;
        endcase
    end

    always_comb begin
        mat_we = 1'b0;
        mat_wa = {i_row, i_col};
        mat_wd = i_data;
        rhs_we = 1'b0;
        rhs_wa = i_row;
        rhs_wd = i_data;
        x_we   = 1'b0;
        x_wa   = r_i[IW-1:0];
        x_wd   = sat32(dq_s);
        case (r_state)
            S_IDLE: begin
                mat_we = o_pop && (i_ctl.kind == K_MAT);
                rhs_we = o_pop && (i_ctl.kind == K_RHS);
            end
            S_M3: begin
                mat_wa = {r_j[IW-1:0], r_k[IW-1:0]};
                mat_wd = rot_j;
                rhs_wa = r_j[IW-1:0];
                rhs_wd = rot_j;
                mat_we = !k_rhs;
                rhs_we = k_rhs;
            end
            S_M5: begin
                mat_wa = {r_i[IW-1:0], r_k[IW-1:0]};
                mat_wd = rot_i;
                rhs_wa = r_i[IW-1:0];
                rhs_wd = rot_i;
                mat_we = !k_rhs;
                rhs_we = k_rhs;
            end
            S_BP2: begin
                x_we = (r_mrd == '0);
                x_wd = '0;
            end
            S_DIV:   x_we = (r_dcnt == 7'd64) && (r_dsel == D_X);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            r_mat[mat_wa] <= mat_wd;
        end
        if (rhs_we) begin
            r_rhs[rhs_wa] <= rhs_wd;
        end
        if (x_we) begin
            r_x[x_wa] <= x_wd;
        end
        r_mrd <= r_mat[mat_ra];
        r_rrd <= r_rhs[rhs_ra];
        r_xrd <= r_x[x_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_sing  <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_ctl.last) begin
                        r_sing <= 1'b0;
                        r_i    <= '0;
                        r_j    <= NW'(1);
                        if (i_n == NW'(1)) begin
                            r_state <= S_BS0;
                        end else begin
                            r_state <= S_PX;
                        end
                    end
                end
                S_PX:  r_state <= S_PY;
                S_PY: begin
                    r_px    <= r_mrd;
                    r_state <= S_PYW;
                end
                S_PYW: begin
                    r_py    <= r_mrd;
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_prod  <= m_p;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_sq    <= 64'(r_prod);
                    r_prod  <= m_p;
                    r_state <= S_SQ3;
                end
                S_SQ3: begin
                    r_sq    <= r_sq + 64'(r_prod);
                    r_root  <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_bit != '0) begin
                        if (r_sq >= sq_try) begin
                            r_sq   <= r_sq - sq_try;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else if (r_root == '0) begin
                        r_sing <= 1'b1;
                        if (more_j) begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_PX;
                        end else if (more_i) begin
                            r_i     <= r_i + 1'b1;
                            r_j     <= r_i + 2'd2;
                            r_state <= S_PX;
                        end else begin
                            r_i     <= i_n - 1'b1;
                            r_state <= S_BS0;
                        end
                    end else begin
                        r_dq    <= abs64(64'(r_px) <<< FRAC_BITS);
                        r_dneg  <= r_px[31];
                        r_dvs   <= r_root;
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_dsel  <= D_C;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dcnt != 7'd64) begin
                        if (dv_try >= {1'b0, r_dvs}) begin
                            r_rem <= dv_try - {1'b0, r_dvs};
                            r_dq  <= {r_dq[62:0], 1'b1};
                        end else begin
                            r_rem <= dv_try;
                            r_dq  <= {r_dq[62:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 1'b1;
                    end else begin
                        case (r_dsel)
                            D_C: begin
                                r_c     <= dq_s[31:0];
                                r_dq    <= abs64(64'(r_py) <<< FRAC_BITS);
                                r_dneg  <= r_py[31];
                                r_rem   <= '0;
                                r_dcnt  <= '0;
                                r_dsel  <= D_S;
                            end
                            D_S: begin
                                r_s     <= -dq_s[31:0];
                                r_k     <= '0;
                                r_state <= S_RU;
                            end
                            default: begin
                                if (r_i == '0) begin
                                    r_k     <= i_n - 1'b1;
                                    r_state <= S_EA;
                                end else begin
                                    r_i     <= r_i - 1'b1;
                                    r_state <= S_BS0;
                                end
                            end
                        endcase
                    end
                end
                S_RU:  r_state <= S_RV;
                S_RV: begin
                    r_u     <= rd_sel;
                    r_state <= S_RV2;
                end
                S_RV2: begin
                    r_v     <= rd_sel;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_prod  <= m_p;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= r_prod;
                    r_prod  <= m_p;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_prod  <= m_p;
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_acc   <= r_prod;
                    r_prod  <= m_p;
                    r_state <= S_M5;
                end
                S_M5: begin
                    if (!k_rhs) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RU;
                    end else if (more_j) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_PX;
                    end else if (more_i) begin
                        r_i     <= r_i + 1'b1;
                        r_j     <= r_i + 2'd2;
                        r_state <= S_PX;
                    end else begin
                        r_i     <= i_n - 1'b1;
                        r_state <= S_BS0;
                    end
                end
                S_BS0: begin
                    r_j     <= r_i + 1'b1;
                    r_state <= S_BS1;
                end
                S_BS1: begin
                    r_acc32 <= r_rrd;
                    r_state <= (r_j < i_n) ? S_BJ : S_BP;
                end
                S_BJ:  r_state <= S_BJ2;
                S_BJ2: begin
                    r_prod  <= m_p;
                    r_state <= S_BJ3;
                end
                S_BJ3: begin
                    r_acc32 <= sat32(64'(r_acc32) - trunc_f(r_prod));
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j + 1'b1 < i_n) ? S_BJ : S_BP;
                end
                S_BP:  r_state <= S_BP2;
                S_BP2: begin
                    if (r_mrd == '0) begin
                        r_sing <= 1'b1;
                        if (r_i == '0) begin
                            r_k     <= i_n - 1'b1;
                            r_state <= S_EA;
                        end else begin
                            r_i     <= r_i - 1'b1;
                            r_state <= S_BS0;
                        end
                    end else begin
                        r_dq    <= abs64(64'(r_acc32) <<< FRAC_BITS);
                        r_dneg  <= r_acc32[31] ^ r_mrd[31];
                        r_dvs   <= abs64(64'(r_mrd));
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_dsel  <= D_X;
                        r_state <= S_DIV;
                    end
                end
                S_EA:  r_state <= S_EB;
                S_EB: begin
                    if (out_free) begin
                        r_ovalue <= r_xrd;
                        r_oindex <= OUT_IDX_W'(r_k);
                        r_osing  <= r_sing;
                        r_olast  <= (r_k == '0);
                        if (r_k == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k - 1'b1;
                            r_state <= S_EA;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tvalid   = r_ov;
    assign o_value    = r_ovalue;
    assign o_index    = r_oindex;
    assign o_singular = r_osing;
    assign o_last     = r_olast;

`ifndef NO_ASSERTIONS
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_olast) |-> (r_oindex == '0))
        else $error("last result not at index zero");

    a_no_store_write_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EA || r_state == S_EB) |-> !(mat_we || rhs_we || x_we))
        else $error("store written while emitting");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt <= 7'd64))
        else $error("divider ran past its length");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_pop && i_ctl.last) |=> (r_state != S_IDLE && !r_sing))
        else $error("solve did not start on final load");
`endif

endmodule

`default_nettype wire

[rtl/givens_qr_linear_solver.sv]
// ----------------------------------------------------------------------------
// givens_qr_linear_solver
// Dense Ax=b solver in signed fixed point using Givens-rotation QR.
//
// s_axis carries one Q16.16 value per transfer: n*n matrix entries row by
// row, then n right-hand-side entries. Loading accepts one transfer per
// cycle while the four-entry queue has room. After the final right-hand-side
// entry the back end solves the system; loads of the next run queue up
// behind it. Each row pair costs a bit-serial square root, two bit-serial
// divisions and a rotation of every column and of the right-hand side on the
// shared multiplier; back substitution costs a multiply-subtract per term
// plus a division per row. m_axis then delivers x from index n-1 down to 0,
// tlast on index 0, tuser holding the singular flag of the run.
// A stalled receiver holds the output register and the back end waits.
// Reset (synchronous, active low) sets n to 16 and restarts loading; a
// write of i_cfg_wdata sets n (0 acts as 1, above MAX_N as MAX_N) and
// restarts loading.
// ----------------------------------------------------------------------------
`default_nettype none

module givens_qr_linear_solver
    import gqr_pkg::*;
#(
    parameter int MAX_N     = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [31:0]       s_axis_tdata,  // value
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [39:0]            m_axis_tdata,  // solution_value, solution_index
    output logic                   m_axis_tuser,  // singular
    output logic                   m_axis_tlast
);

    localparam int IW = $clog2(MAX_N);
    localparam int NW = $clog2(MAX_N+1);
    localparam int QW = 2 + 2*IW + DATA_W;

    logic [CFG_W-1:0]        r_size;
    logic [NW-1:0]           n_cur;
    logic                    push;
    logic                    full;
    t_ctl                    f_ctl;
    logic [IW-1:0]           f_row;
    logic [IW-1:0]           f_col;
    logic [DATA_W-1:0]       f_data;
    logic [QW-1:0]           q_out;
    logic                    q_valid;
    logic                    pop;
    logic signed [31:0]      sol_value;
    logic [OUT_IDX_W-1:0]    sol_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CFG_W'(16);
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_size == '0) begin
            n_cur = NW'(1);
        end else if (int'(r_size) > MAX_N) begin
            n_cur = NW'(MAX_N);
        end else begin
            n_cur = NW'(r_size);
        end
    end

    gqr_front #(.MAX_N(MAX_N)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_n      (n_cur),
        .i_clear  (i_cfg_we),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_full   (full),
        .o_push   (push),
        .o_ctl    (f_ctl),
        .o_row    (f_row),
        .o_col    (f_col),
        .o_data   (f_data)
    );

    gqr_fifo #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_row, f_col, f_data}),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_out)
    );

    gqr_back #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n         (n_cur),
        .i_pop_valid (q_valid),
        .o_pop       (pop),
        .i_ctl       (t_ctl'(q_out[QW-1 -: 2])),
        .i_row       (q_out[DATA_W+IW +: IW]),
        .i_col       (q_out[DATA_W +: IW]),
        .i_data      (q_out[DATA_W-1:0]),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_value     (sol_value),
        .o_index     (sol_index),
        .o_singular  (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, sol_index, sol_value};

endmodule

`default_nettype wire

[test/tb_givens_qr_linear_solver.sv]
// ----------------------------------------------------------------------------
// tb_givens_qr_linear_solver
// Self-checking testbench for the Givens QR linear solver. Matrices and
// right-hand sides are streamed in, and a local fixed-point solver predicts
// each solution transfer. Results are checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_givens_qr_linear_solver;
    import gqr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NMAX  = 16;
    localparam int FRAC  = 16;
    localparam int WDOG  = 400000;
    localparam int DRAIN = 200;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         index;
        logic               singular;
        logic               last;
    } t_soln;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [4:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    givens_qr_linear_solver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic signed [31:0] mat [NMAX*NMAX];
    logic signed [31:0] rhs [NMAX];
    int unsigned        load_cnt;
    int unsigned        size_reg;
    t_soln              soln_q [$];
    int                 errors;
    int                 src_idle;
    int                 snk_idle;
    int                 quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_n();
        if (size_reg == 0) return 1;
        if (size_reg > NMAX) return NMAX;
        return size_reg;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clip(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic solve_system(input int unsigned n);
        logic signed [63:0] one;
        logic signed [63:0] px, py, r, c, s, u, v, p, prod;
        logic [63:0]        sq;
        logic signed [31:0] x [NMAX];
        logic signed [31:0] acc;
        logic               sing;
        t_soln              e;
        one = 64'sd1 <<< FRAC;
        sing = 1'b0;
        for (int i = 0; i < NMAX; i++) x[i] = 0;
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                px = mat[i*NMAX+i];
                py = mat[j*NMAX+i];
                sq = 64'(px * px) + 64'(py * py);
                r = $signed(isqrt(sq));
                if (r == 0) begin
                    sing = 1'b1;
                    continue;
                end
                c = (px * one) / r;
                s = -((py * one) / r);
                for (int k = 0; k < n; k++) begin
                    u = mat[i*NMAX+k];
                    v = mat[j*NMAX+k];
                    mat[j*NMAX+k] = clip((s * u + c * v) / one);
                    mat[i*NMAX+k] = clip((c * u - s * v) / one);
                end
                u = rhs[i];
                v = rhs[j];
                rhs[j] = clip((s * u + c * v) / one);
                rhs[i] = clip((c * u - s * v) / one);
            end
        end
        for (int row = n - 1; row >= 0; row--) begin
            acc = rhs[row];
            for (int j = row + 1; j < n; j++) begin
                prod = 64'(mat[row*NMAX+j]) * 64'(x[j]);
                acc = clip(64'(acc) - prod / one);
            end
            p = mat[row*NMAX+row];
            if (p == 0) begin
                sing = 1'b1;
                x[row] = 0;
            end else begin
                x[row] = clip((64'(acc) * one) / p);
            end
        end
        for (int idx = n - 1; idx >= 0; idx--) begin
            e.value = x[idx];
            e.index = 4'(idx);
            e.singular = sing;
            e.last = (idx == 0);
            soln_q.push_back(e);
        end
    endtask

    task automatic predict_load(input logic signed [31:0] val);
        int unsigned n;
        n = eff_n();
        if (load_cnt < n * n) begin
            mat[(load_cnt / n) * NMAX + (load_cnt % n)] = val;
            load_cnt++;
            return;
        end
        rhs[(load_cnt - n * n) % n] = val;
        load_cnt++;
        if (load_cnt < n * n + n) return;
        load_cnt = 0;
        solve_system(n);
    endtask

    task automatic send_value(input logic [31:0] val);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_load(val);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (soln_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_size(input logic [4:0] sz);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sz;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = sz;
        load_cnt = 0;
    endtask

    function automatic logic [31:0] rand_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
            default: return 32'($signed($urandom_range(512)) - 256);
        endcase
    endfunction

    task automatic send_system(input int unsigned n, input int mode, input bit diag_dom);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (diag_dom && r == c) begin
                    send_value(32'((n + 2) << FRAC) + ($urandom_range(1 << FRAC)));
                end else begin
                    send_value(rand_value(mode));
                end
            end
        end
        for (int r = 0; r < n; r++) send_value(rand_value(mode));
    endtask

    task automatic test_directed();
        write_size(5'd1);
        send_value(32'h0001_0000);
        send_value(32'h7fff_ffff);
        send_value(32'h0000_0000);
        send_value(32'h8000_0000);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        write_size(5'd2);
        send_value(32'h0000_0000);
        send_value(32'h0000_0000);
        send_value(32'h0000_0000);
        send_value(32'h0001_0000);
        send_value(32'h0003_0000);
        send_value(32'hfffe_0000);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(32'hffff_ffff);
        send_value(32'h0000_0001);
        // abandon a partial load by rewriting the size
        send_value(32'h1234_5678);
        write_size(5'd0);
        send_value(32'h0002_0000);
        send_value(32'hffff_0000);
    endtask

    task automatic test_sizes();
        write_size(5'd31);
        repeat (4) send_value(rand_value(0));
        write_size(5'd17);
        repeat (4) send_value(rand_value(1));
        write_size(5'd5);
        send_system(5, 1, 1'b1);
    endtask

    task automatic test_random(input int s_idle, input int r_idle, input int items);
        int unsigned n;
        int sent;
        src_idle = s_idle;
        snk_idle = r_idle;
        sent = 0;
        while (sent < items) begin
            n = $urandom_range(4, 2);
            if ($urandom_range(9) == 0) n = $urandom_range(1, 3);
            write_size(5'(n));
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(n * n)) send_value($urandom);
                write_size(5'(n));
            end
            send_system(n, $urandom_range(2), $urandom_range(1));
            sent += n * n + n;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        errors        = 0;
        src_idle      = 0;
        snk_idle      = 0;
        load_cnt      = 0;
        size_reg      = 16;
        for (int i = 0; i < NMAX * NMAX; i++) mat[i] = 0;
        for (int i = 0; i < NMAX; i++) rhs[i] = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(15, 53, 30);
        test_random(53, 15, 30);
        test_random(0, 0, 30);
        test_sizes();
        wait_drained();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin
        t_soln got;
        t_soln want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value    = m_axis_tdata[31:0];
            got.index    = m_axis_tdata[35:32];
            got.singular = m_axis_tuser;
            got.last     = m_axis_tlast;
            if (soln_q.size() == 0) begin
                $display("%0t unexpected transfer: actual %h", $time, got);
                errors++;
            end else begin
                want = soln_q.pop_front();
                if (got.value !== want.value || got.index !== want.index
                        || got.singular !== want.singular || got.last !== want.last) begin
                    $display("%0t mismatch: expected val %h idx %0d sing %b last %b, actual val %h idx %0d sing %b last %b",
                             $time, want.value, want.index, want.singular, want.last,
                             got.value, got.index, got.singular, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (!s_axis_tvalid && soln_q.size() == 0)) begin
            quiet <= 0;
        end else if (quiet >= WDOG) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial quiet = 0;

endmodule

`default_nettype wire
